// File: rtl/core/fgks_pkg.sv
// Shared types and constants for the functional-graph k-th successor block.
// Used by fgks_mod_unit, fgks_walker and functional_graph_kth_successor.
`timescale 1ns / 1ps

package fgks_pkg;

    // Fixed field widths of the item and result beats.
    localparam int NODE_W  = 10;
    localparam int STEPS_W = 32;

    // Width of the query tag kept next to each first-visit entry.
    localparam int EPOCH_W = 8;

    // Operation codes of an input beat.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_DIV,
        ST_PATH,
        ST_FINISH
    } fgks_state_t;

    // One input beat as it travels to the walker.
    typedef struct packed {
        logic               opcode;
        logic [NODE_W-1:0]  entry_index;
        logic [NODE_W-1:0]  entry_successor;
        logic [NODE_W-1:0]  start_node;
        logic [STEPS_W-1:0] step_count;
    } fgks_req_t;

    // Walker status seen by the handshake logic.
    typedef struct packed {
        logic idle;
        logic res_valid;
    } fgks_stat_t;

endpackage

// File: rtl/core/fgks_mod_unit.sv
// Iterative remainder unit: one restoring-division bit per cycle.
// Depends on fgks_pkg for the dividend width.
`timescale 1ns / 1ps

module fgks_mod_unit #(
    parameter int DIVISOR_W = 11
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [fgks_pkg::STEPS_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]         divisor,
    output logic                         done,
    output logic [DIVISOR_W-1:0]         remainder
);

    localparam int CNT_W = $clog2(fgks_pkg::STEPS_W);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [fgks_pkg::STEPS_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]         dsr_reg, dsr_next;
    logic [DIVISOR_W-1:0]         rem_reg, rem_next;
    logic [DIVISOR_W:0]           trial;
    logic [DIVISOR_W:0]           diff;

    always_comb begin
        trial     = {rem_reg, dvd_reg[fgks_pkg::STEPS_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(fgks_pkg::STEPS_W - 1);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // The partial remainder stays below the divisor, so one
            // compare and subtract per bit keeps it in range.
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[DIVISOR_W-1:0];
            end else begin
                rem_next = trial[DIVISOR_W-1:0];
            end
            dvd_next = {dvd_reg[fgks_pkg::STEPS_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/fgks_walker.sv
// Sequencer, successor table, first-visit store and path store of the walk.
// Depends on fgks_pkg and instantiates fgks_mod_unit for the cycle jump.
`timescale 1ns / 1ps

module fgks_walker #(
    parameter int NUM_NODES = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        req_valid,
    input  fgks_pkg::fgks_req_t         req,
    input  logic                        res_ready,
    output fgks_pkg::fgks_stat_t        stat,
    output logic [fgks_pkg::NODE_W-1:0] res_node
);

    localparam int IDX_W  = $clog2(NUM_NODES);
    localparam int STEP_W = $clog2(NUM_NODES + 2);
    localparam int PATH_W = $clog2(NUM_NODES + 1);
    localparam int FV_W   = fgks_pkg::EPOCH_W + STEP_W;

    // Memories.
    logic [fgks_pkg::NODE_W-1:0] succ_mem [NUM_NODES];
    logic [FV_W-1:0]             fv_mem   [NUM_NODES];
    logic [fgks_pkg::NODE_W-1:0] path_mem [NUM_NODES+1];

    logic [fgks_pkg::NODE_W-1:0] succ_rd;
    logic [FV_W-1:0]             fv_rd;
    logic [fgks_pkg::NODE_W-1:0] path_rd;

    // Sequencer registers.
    fgks_pkg::fgks_state_t        state_reg, state_next;
    logic [fgks_pkg::NODE_W-1:0]  cur_reg, cur_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic [fgks_pkg::STEPS_W-1:0] steps_reg, steps_next;
    logic [STEP_W-1:0]            first_reg, first_next;
    logic [fgks_pkg::NODE_W-1:0]  res_reg, res_next;
    logic [fgks_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [IDX_W-1:0]             clr_reg, clr_next;

    // Memory port controls.
    logic                         accept;
    logic                         succ_we;
    logic                         fv_we;
    logic [IDX_W-1:0]             fv_waddr;
    logic [FV_W-1:0]              fv_wdata;
    logic                         path_we;
    logic [PATH_W-1:0]            path_waddr;
    logic [fgks_pkg::NODE_W-1:0]  path_wdata;
    logic [PATH_W-1:0]            path_raddr;
    logic [STEP_W:0]              path_idx;
    logic [fgks_pkg::NODE_W-1:0]  rd_node;
    logic [IDX_W-1:0]             rd_idx;

    // Walk decisions.
    logic                         step_over;
    logic                         out_of_range;
    logic                         visited;
    logic [fgks_pkg::EPOCH_W-1:0] fv_tag;
    logic [STEP_W-1:0]            fv_step;

    // Remainder unit.
    logic                         div_start;
    logic [fgks_pkg::STEPS_W-1:0] div_dividend;
    logic [STEP_W-1:0]            div_divisor;
    logic                         div_done;
    logic [STEP_W-1:0]            div_rem;

    fgks_mod_unit #(
        .DIVISOR_W (STEP_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb begin
        accept       = req_valid && (state_reg == fgks_pkg::ST_IDLE);
        step_over    = 32'(step_reg) > steps_reg;
        out_of_range = 32'(cur_reg) >= 32'(NUM_NODES);
        fv_tag       = fv_rd[FV_W-1:STEP_W];
        fv_step      = fv_rd[STEP_W-1:0];
        visited      = (fv_tag == epoch_reg);
        rd_node      = (state_reg == fgks_pkg::ST_STEP) ? succ_rd : req.start_node;
        rd_idx       = IDX_W'(rd_node);
        path_idx     = {1'b0, first_reg} - (STEP_W+1)'(1) + {1'b0, div_rem};
        path_raddr   = path_idx[PATH_W-1:0];
        div_dividend = steps_reg - 32'(step_reg) + 32'd1;
        div_divisor  = step_reg - fv_step;

        state_next = state_reg;
        cur_next   = cur_reg;
        step_next  = step_reg;
        steps_next = steps_reg;
        first_next = first_reg;
        res_next   = res_reg;
        epoch_next = epoch_reg;
        clr_next   = clr_reg;
        succ_we    = 1'b0;
        fv_we      = 1'b0;
        fv_waddr   = IDX_W'(cur_reg);
        fv_wdata   = {epoch_reg, step_reg};
        path_we    = 1'b0;
        path_waddr = PATH_W'(step_reg);
        path_wdata = succ_rd;
        div_start  = 1'b0;

        unique case (state_reg)
            fgks_pkg::ST_CLEAR: begin
                fv_we    = 1'b1;
                fv_waddr = clr_reg;
                fv_wdata = '0;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(NUM_NODES - 1)) begin
                    state_next = fgks_pkg::ST_IDLE;
                end
            end
            fgks_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (req.opcode)
                        fgks_pkg::OP_LOAD: begin
                            succ_we = 32'(req.entry_index) < 32'(NUM_NODES);
                        end
                        fgks_pkg::OP_QUERY: begin
                            cur_next   = req.start_node;
                            step_next  = STEP_W'(1);
                            steps_next = req.step_count;
                            path_we    = 1'b1;
                            path_waddr = '0;
                            path_wdata = req.start_node;
                            state_next = fgks_pkg::ST_STEP;
                        end
                        default: begin
                            state_next = fgks_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            fgks_pkg::ST_STEP: begin
                if (step_over || out_of_range || (succ_rd == cur_reg)) begin
                    res_next   = cur_reg;
                    state_next = fgks_pkg::ST_FINISH;
                end else if (visited) begin
                    first_next = fv_step;
                    div_start  = 1'b1;
                    state_next = fgks_pkg::ST_DIV;
                end else begin
                    fv_we     = 1'b1;
                    path_we   = 32'(step_reg) <= 32'(NUM_NODES);
                    cur_next  = succ_rd;
                    step_next = step_reg + STEP_W'(1);
                end
            end
            fgks_pkg::ST_DIV: begin
                if (div_done) begin
                    if ((div_rem == '0) || (path_idx == '0)) begin
                        res_next   = cur_reg;
                        state_next = fgks_pkg::ST_FINISH;
                    end else begin
                        state_next = fgks_pkg::ST_PATH;
                    end
                end
            end
            fgks_pkg::ST_PATH: begin
                res_next   = path_rd;
                state_next = fgks_pkg::ST_FINISH;
            end
            fgks_pkg::ST_FINISH: begin
                if (res_ready) begin
                    if (epoch_reg == '1) begin
                        epoch_next = fgks_pkg::EPOCH_W'(1);
                        clr_next   = '0;
                        state_next = fgks_pkg::ST_CLEAR;
                    end else begin
                        epoch_next = epoch_reg + fgks_pkg::EPOCH_W'(1);
                        state_next = fgks_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = fgks_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fgks_pkg::ST_CLEAR;
            epoch_reg <= fgks_pkg::EPOCH_W'(1);
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            epoch_reg <= epoch_next;
            clr_reg   <= clr_next;
        end
        cur_reg   <= cur_next;
        step_reg  <= step_next;
        steps_reg <= steps_next;
        first_reg <= first_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (succ_we) begin
            succ_mem[IDX_W'(req.entry_index)] <= req.entry_successor;
        end
        succ_rd <= succ_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (fv_we) begin
            fv_mem[fv_waddr] <= fv_wdata;
        end
        fv_rd <= fv_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (path_we) begin
            path_mem[path_waddr] <= path_wdata;
        end
        path_rd <= path_mem[path_raddr];
    end

    assign stat.idle      = (state_reg == fgks_pkg::ST_IDLE);
    assign stat.res_valid = (state_reg == fgks_pkg::ST_FINISH);
    assign res_node       = res_reg;

    // The walk meets a repeated node no later than one step past the table size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fgks_pkg::ST_STEP) |-> (32'(step_reg) <= 32'(NUM_NODES) + 32'd1))
        else $error("walk step count ran past the table size");

    // The remainder unit reports only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == fgks_pkg::ST_DIV))
        else $error("remainder unit finished outside the cycle jump");

    // A path lookup follows only a finished remainder.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fgks_pkg::ST_PATH) |-> ($past(state_reg) == fgks_pkg::ST_DIV))
        else $error("path lookup without a cycle jump");

    // Every delivered query moves to a fresh tag so old first-visit entries go stale.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == fgks_pkg::ST_FINISH) && res_ready) |=> (epoch_reg != $past(epoch_reg)))
        else $error("query tag did not advance");

endmodule

// File: rtl/core/functional_graph_kth_successor.sv
// Top level of the functional-graph k-th successor block: handshakes and result register.
// Depends on fgks_pkg and instantiates fgks_walker.
`timescale 1ns / 1ps

// The block holds a successor table of NUM_NODES nodes, each pointing to one next node,
// and answers "where do I stand after step_count moves from start_node". A load beat
// (opcode 0) writes one table entry and returns no beat; a load whose index is at or
// beyond NUM_NODES is dropped. A query beat (opcode 1) returns one beat on the m_
// channel. The walk reads one table entry per cycle, and a walk makes at most
// min(NUM_NODES, 1024) moves before it stops or meets a node again. When the walk meets
// a node for the second time it knows the cycle length and jumps ahead: a bit-serial
// remainder unit reduces the remaining moves modulo that length, and unless the
// remainder is zero the end node is read from the recorded path. A walk that stands on
// a self-loop or on a node outside the table stops there. The block is busy (s_ready
// low) for the whole of a query. After reset, and again after every 255th query, a
// clearing pass over all NUM_NODES entries resets the first-visit tags; no input beat
// is taken during it. Reading a table entry that was never loaded gives an undefined
// answer. A finished result waits in an output register, so the next beat can be taken
// while m_ready is low.

module functional_graph_kth_successor #(
    parameter int NUM_NODES = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_opcode,
    input  logic [fgks_pkg::NODE_W-1:0]  s_entry_index,
    input  logic [fgks_pkg::NODE_W-1:0]  s_entry_successor,
    input  logic [fgks_pkg::NODE_W-1:0]  s_start_node,
    input  logic [fgks_pkg::STEPS_W-1:0] s_step_count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [fgks_pkg::NODE_W-1:0]  m_end_node
);

    fgks_pkg::fgks_req_t         req;
    fgks_pkg::fgks_stat_t        stat;
    logic [fgks_pkg::NODE_W-1:0] res_node;
    logic                        res_ready;

    logic                        m_valid_reg, m_valid_next;
    logic [fgks_pkg::NODE_W-1:0] m_end_node_reg, m_end_node_next;

    // The walker sees the input beat as one bundle.
    assign req.opcode          = s_opcode;
    assign req.entry_index     = s_entry_index;
    assign req.entry_successor = s_entry_successor;
    assign req.start_node      = s_start_node;
    assign req.step_count      = s_step_count;

    // The walker only takes a beat while it sits idle.
    assign s_ready = stat.idle;

    // A finished result can move into the output register when the register is
    // empty or its current beat leaves in this cycle.
    assign res_ready = !m_valid_reg || m_ready;

    fgks_walker #(
        .NUM_NODES (NUM_NODES)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req       (req),
        .res_ready (res_ready),
        .stat      (stat),
        .res_node  (res_node)
    );

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_end_node_next = m_end_node_reg;
        if (stat.res_valid && res_ready) begin
            m_valid_next    = 1'b1;
            m_end_node_next = res_node;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_end_node_reg <= m_end_node_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_end_node = m_end_node_reg;

endmodule

// File: tb/functional_graph_kth_successor_tb.sv
// Self-checking testbench for functional_graph_kth_successor: loads random successor graphs,
// queries k-th successors and checks every end_node beat against an in-bench walk predictor.
// Depends on fgks_pkg and the block's RTL; needs no files or arguments.
`timescale 1ns / 1ps

module functional_graph_kth_successor_tb;

    localparam int NODES       = 1024;
    // Worst quiet stretch: a clearing pass, a full-depth query with a cycle jump, and the
    // longest stall on either side. The watchdog allows several times that.
    localparam int STALL_LIMIT = 20000;
    // Drain time after the last expected beat; about one worst-case query.
    localparam int DRAIN_CYCLES = 1100;
    localparam int ITEM_BUDGET = 540;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_opcode = fgks_pkg::OP_LOAD;
    logic [fgks_pkg::NODE_W-1:0]   s_entry_index = '0;
    logic [fgks_pkg::NODE_W-1:0]   s_entry_successor = '0;
    logic [fgks_pkg::NODE_W-1:0]   s_start_node = '0;
    logic [fgks_pkg::STEPS_W-1:0]  s_step_count = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [fgks_pkg::NODE_W-1:0]   m_end_node;

    functional_graph_kth_successor #(
        .NUM_NODES(NODES)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_entry_index(s_entry_index),
        .s_entry_successor(s_entry_successor),
        .s_start_node(s_start_node),
        .s_step_count(s_step_count),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_end_node(m_end_node)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------------------
    // Beats waiting to be driven, and the end nodes predicted for accepted queries.
    // ------------------------------------------------------------------------------------
    fgks_pkg::fgks_req_t         pending_beats[$];
    logic [fgks_pkg::NODE_W-1:0] expected_ends[$];

    int unsigned n_loads = 0;
    int unsigned n_queries = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;

    // Stimulus-side view of the table. It only decides which queries are legal: a query
    // must never make the block read an entry that was not loaded since reset.
    logic [fgks_pkg::NODE_W-1:0] plan_next[NODES];
    bit                          plan_loaded[NODES];
    logic [fgks_pkg::NODE_W-1:0] loaded_nodes[$];
    bit                          picked[NODES];

    // Predictor state: its own copy of the successor table and the walk scratch stores.
    logic [fgks_pkg::NODE_W-1:0] pred_next[NODES];
    bit                          pred_seen[NODES];
    logic [10:0]                 pred_first[NODES];
    logic [fgks_pkg::NODE_W-1:0] pred_path[0:NODES];

    // Walks from start for the given number of moves. Each node records the move on which
    // it was first left, and pred_path holds the node reached after each move. Meeting a
    // node again gives the cycle length, and the answer is read from the recorded path at
    // the remaining moves modulo that length. A self-loop, or a remainder of zero, leaves
    // the walk where it stands. With ten-bit nodes and a full-size table, a node past the
    // end of the table cannot occur here.
    function automatic logic [fgks_pkg::NODE_W-1:0] kth_successor(
            input logic [fgks_pkg::NODE_W-1:0] start,
            input logic [fgks_pkg::STEPS_W-1:0] steps);
        logic [fgks_pkg::NODE_W-1:0] cur;
        logic [fgks_pkg::NODE_W-1:0] nxt;
        logic [32:0]                 step;
        logic [32:0]                 cyc;
        logic [32:0]                 remaining;
        logic [32:0]                 rem;
        logic [32:0]                 idx;
        cur = start;
        for (int i = 0; i < NODES; i++) pred_seen[i] = 1'b0;
        step = 33'd1;
        while (step <= {1'b0, steps}) begin
            nxt = pred_next[cur];
            if (nxt == cur) return cur;
            if (!pred_seen[cur]) begin
                pred_seen[cur] = 1'b1;
                pred_first[cur] = step[10:0];
                cur = nxt;
                if (step <= NODES) pred_path[step[10:0]] = cur;
            end else begin
                cyc = step - {22'd0, pred_first[cur]};
                remaining = {1'b0, steps} - step + 33'd1;
                if (cyc == 0) return cur;
                rem = remaining % cyc;
                if (rem == 0) return cur;
                idx = {22'd0, pred_first[cur]} - 33'd1 + rem;
                if (idx == 0 || idx > NODES) return cur;
                return pred_path[idx[10:0]];
            end
            step = step + 33'd1;
        end
        return cur;
    endfunction

    // A walk never reads more than NODES + 1 entries before it stops or finds its cycle,
    // so following the planned table that far shows every entry the query touches.
    function automatic bit walk_is_defined(input logic [fgks_pkg::NODE_W-1:0] start,
                                           input logic [fgks_pkg::STEPS_W-1:0] steps);
        logic [fgks_pkg::NODE_W-1:0] at;
        int                          lim;
        at = start;
        lim = (steps > 32'd1025) ? 1025 : int'(steps);
        for (int n = 0; n < lim; n++) begin
            if (!plan_loaded[at]) return 1'b0;
            if (plan_next[at] == at) return 1'b1;
            at = plan_next[at];
        end
        return 1'b1;
    endfunction

    // Idle lengths: mostly none or short, a few long. During a calm stretch there are none.
    function automatic int unsigned idle_len(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [fgks_pkg::NODE_W-1:0] any_node();
        return fgks_pkg::NODE_W'($urandom_range(0, NODES - 1));
    endfunction

    // The fields a load does not use carry random values, so every bit toggles anyway.
    task automatic add_load(input logic [fgks_pkg::NODE_W-1:0] node,
                            input logic [fgks_pkg::NODE_W-1:0] succ);
        fgks_pkg::fgks_req_t b;
        b.opcode = fgks_pkg::OP_LOAD;
        b.entry_index = node;
        b.entry_successor = succ;
        b.start_node = any_node();
        b.step_count = $urandom;
        pending_beats.push_back(b);
        plan_next[node] = succ;
        if (!plan_loaded[node]) begin
            plan_loaded[node] = 1'b1;
            loaded_nodes.push_back(node);
        end
        n_loads++;
    endtask

    // Queries that would read an unloaded entry are dropped here.
    task automatic add_query(input logic [fgks_pkg::NODE_W-1:0] start,
                             input logic [fgks_pkg::STEPS_W-1:0] steps);
        fgks_pkg::fgks_req_t b;
        if (!walk_is_defined(start, steps)) return;
        b.opcode = fgks_pkg::OP_QUERY;
        b.entry_index = any_node();
        b.entry_successor = any_node();
        b.start_node = start;
        b.step_count = steps;
        pending_beats.push_back(b);
        n_queries++;
    endtask

    function automatic logic [fgks_pkg::NODE_W-1:0] any_loaded_node();
        return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
    endfunction

    // Builds a tail of tail_len distinct nodes leading into a cycle of cyc_len nodes (a
    // cycle of one is a self-loop), or, when grafted, a chain that ends on a node loaded
    // earlier. Then it queries the shape with step counts aimed at its boundaries: zero,
    // exactly reaching the cycle, whole multiples of the cycle (zero remainder), and full
    // 32-bit counts.
    task automatic add_shape(input int unsigned tail_len, input int unsigned cyc_len,
                             input bit graft);
        logic [fgks_pkg::NODE_W-1:0]  chain[$];
        logic [fgks_pkg::NODE_W-1:0]  n;
        logic [fgks_pkg::NODE_W-1:0]  start;
        logic [fgks_pkg::STEPS_W-1:0] steps;
        int unsigned                  len;
        int unsigned                  nq;
        int unsigned                  r;
        len = tail_len + cyc_len;
        for (int i = 0; i < NODES; i++) picked[i] = 1'b0;
        for (int i = 0; i < len; i++) begin
            n = any_node();
            while (picked[n]) n = any_node();
            picked[n] = 1'b1;
            chain.push_back(n);
        end
        for (int i = 0; i < len - 1; i++) add_load(chain[i], chain[i + 1]);
        if (graft && loaded_nodes.size() > 0) begin
            add_load(chain[len - 1], any_loaded_node());
        end else begin
            add_load(chain[len - 1], chain[tail_len]);
        end
        nq = $urandom_range(8, 16);
        for (int q = 0; q < nq; q++) begin
            r = $urandom_range(0, 99);
            if (r < 50) start = chain[0];
            else if (r < 80) start = chain[$urandom_range(0, len - 1)];
            else start = any_loaded_node();
            case ($urandom_range(0, 9))
                0: steps = 0;
                1: steps = 1;
                2: steps = $urandom_range(1, len + 2);
                3: steps = len;
                4: steps = tail_len + $urandom_range(1, 1000000) * cyc_len;
                5: steps = tail_len + $urandom_range(1, 1000000) * cyc_len
                           + $urandom_range(1, cyc_len);
                6: steps = $urandom;
                7: steps = 32'hFFFF_FFFF;
                8: steps = $urandom_range(0, 20);
                default: steps = $urandom >> $urandom_range(0, 31);
            endcase
            add_query(start, steps);
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned r;
        for (int i = 0; i < NODES; i++) plan_loaded[i] = 1'b0;

        // Directed part: a tail into a three-node cycle, a self-loop on the top node, and
        // table extremes on both the index and the successor.
        add_load(10'd0, 10'd1);
        add_load(10'd1, 10'd2);
        add_load(10'd2, 10'd3);
        add_load(10'd3, 10'd1);
        add_load(10'd1023, 10'd1023);
        add_load(10'd1022, 10'd1023);
        add_load(10'd5, 10'd0);
        add_query(10'd0, 32'd0);            // zero moves
        add_query(10'd600, 32'd0);          // zero moves from a node never loaded
        add_query(10'd1023, 32'd0);
        add_query(10'd0, 32'd1);
        add_query(10'd0, 32'd3);
        add_query(10'd0, 32'd4);            // first revisit
        add_query(10'd1023, 32'hFFFF_FFFF); // self-loop with the largest count
        add_query(10'd1022, 32'd1);
        add_query(10'd1022, 32'd5);         // runs into the self-loop
        add_query(10'd3, 32'd300);          // cycle jump with zero remainder
        add_query(10'd3, 32'd301);          // cycle jump to the first recorded node
        add_query(10'd5, 32'd100);
        add_query(10'd0, 32'hFFFF_FFFF);

        // Random part: one large shape for deep walks, then mostly small shapes with
        // random content and a little noise of stray loads and odd queries.
        add_shape($urandom_range(30, 50), $urandom_range(60, 80), 1'b0);
        while (n_loads + n_queries < ITEM_BUDGET) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                repeat ($urandom_range(1, 3)) begin
                    add_load(any_node(), any_node());
                end
                add_query(any_loaded_node(), $urandom);
                add_query(any_node(), 32'd0);
            end else if (r < 25) begin
                add_shape($urandom_range(0, 25), $urandom_range(1, 35), $urandom_range(0, 3) == 0);
            end else begin
                add_shape($urandom_range(0, 5), $urandom_range(1, 6), $urandom_range(0, 4) == 0);
            end
        end

        // Reset is released on a falling edge.
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The pending queue only changes on falling edges, so it is read on rising ones;
        // the expected queue is the other way round.
        @(posedge aclk);
        while (pending_beats.size() != 0 || s_valid) @(posedge aclk);
        @(negedge aclk);
        while (expected_ends.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Run covered %0d table loads and %0d successor queries; %0d result beats checked.",
                 n_loads, n_queries, n_checked);
        $display("Both channels saw random idle gaps and stalls, short, long and absent.");
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Input driver. It works on falling edges and looks at the handshake sampled on the
    // previous rising edge. A beat holds its payload until it is taken; after each beat a
    // random gap may follow. Calm stretches switch the gaps off for a while.
    // ------------------------------------------------------------------------------------
    bit                  s_beat_taken = 1'b0;
    bit                  s_calm = 1'b0;
    int unsigned         s_gap = 0;
    fgks_pkg::fgks_req_t next_beat;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_beat_taken) begin
            // Still waiting for the block to take the current beat.
        end else if (s_gap > 0) begin
            s_valid <= 1'b0;
            s_gap = s_gap - 1;
        end else if (pending_beats.size() > 0) begin
            next_beat = pending_beats.pop_front();
            s_valid <= 1'b1;
            s_opcode <= next_beat.opcode;
            s_entry_index <= next_beat.entry_index;
            s_entry_successor <= next_beat.entry_successor;
            s_start_node <= next_beat.start_node;
            s_step_count <= next_beat.step_count;
            if ($urandom_range(0, 24) == 0) s_calm = !s_calm;
            s_gap = idle_len(s_calm);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result-side ready. Stalls start after a beat is taken, or now and then while
    // waiting, so that they land on every phase of the block's work.
    bit          m_beat_taken = 1'b0;
    bit          m_calm = 1'b0;
    int unsigned m_stall = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_stall > 0) begin
            m_ready <= 1'b0;
            m_stall = m_stall - 1;
        end else begin
            m_ready <= 1'b1;
            if (m_beat_taken || $urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 19) == 0) m_calm = !m_calm;
                m_stall = idle_len(m_calm);
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Monitor. On each rising edge, an accepted input beat updates the predictor (loads)
    // or queues the predicted end node (queries), and an accepted result beat is checked
    // against the oldest prediction. A result cannot leave on the edge its query enters,
    // so handling both in one block keeps the queue in order.
    // ------------------------------------------------------------------------------------
    logic [fgks_pkg::NODE_W-1:0] want_end;

    always @(posedge aclk) begin
        m_beat_taken = aresetn && m_valid && m_ready;
        s_beat_taken = aresetn && s_valid && s_ready;
        if (m_beat_taken) begin
            if (expected_ends.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, got end_node %0d",
                         $time, m_end_node);
                n_errors++;
            end else begin
                want_end = expected_ends.pop_front();
                n_checked++;
                if (m_end_node !== want_end) begin
                    $display("%0t: end_node mismatch, expected %0d, got %0d",
                             $time, want_end, m_end_node);
                    n_errors++;
                end
            end
        end
        if (s_beat_taken) begin
            // With a full-size table every ten-bit index is in range, so no load is dropped.
            if (s_opcode == fgks_pkg::OP_LOAD) begin
                pred_next[s_entry_index] = s_entry_successor;
            end else begin
                expected_ends.push_back(kth_successor(s_start_node, s_step_count));
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either channel for too long.
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
